// ===== hdl/sem_pkg.sv =====
package sem_pkg;

    localparam int PIX_W     = 8;
    localparam int ROW_W     = 12;
    localparam int COL_W     = 11;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 12'd480;
    localparam logic [CFG_W-1:0] MIN_SIZE           = 12'd3;

    localparam int COL_SUM_W = PIX_W + 2;
    localparam int DIFF_W    = PIX_W + 1;
    localparam int GRAD_W    = PIX_W + 3;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             frame_start;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             frame_last;
    } out_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } win_col_t;

    typedef struct packed {
        logic        [COL_SUM_W-1:0] col_sum;
        logic signed [DIFF_W-1:0]    vert_diff;
    } col_tap_t;

endpackage

// ===== hdl/sem_ram.sv =====
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/sem_col_cell.sv =====
module sem_col_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              shift_en,
    input  sem_pkg::win_col_t col_in,
    output sem_pkg::win_col_t col_out,
    output sem_pkg::col_tap_t tap
);

    sem_pkg::win_col_t col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (shift_en) begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

    // weighted column sum and bottom minus top
    assign tap.col_sum = sem_pkg::COL_SUM_W'(col_reg.top)
                       + sem_pkg::COL_SUM_W'({col_reg.mid, 1'b0})
                       + sem_pkg::COL_SUM_W'(col_reg.bot);
    assign tap.vert_diff = $signed({1'b0, col_reg.bot}) - $signed({1'b0, col_reg.top});

endmodule

// ===== hdl/sobel_edge_magnitude_3x3_top.sv =====
// 3x3 Sobel edge magnitude over a raster-order stream of 8-bit grey pixels.
// Input channel s_valid/s_ready/s_data carries one pixel per request; frame_start
// puts that pixel at row 0, column 0. Output channel m_valid/m_ready/m_data carries
// one result per interior pixel (row and column of the window center, the rounded
// mean of the saturated |Gx| and |Gy|, and frame_last on the last interior pixel).
// Border positions produce no output request.
// Width and height are set through cfg_wr_en/cfg_index/cfg_wdata while idle.
// Throughput: one pixel per cycle while s_ready is high; each pixel takes one read and
// one write on each line store RAM and one shift of the three-cell column chain.
// A result passes stages a, b and c and the output queue before it reaches m_valid.
// When the receiver stalls, results collect in an 8-entry output queue and
// s_ready drops once 8 requests are outstanding in the pipeline and queue.
// Reset: size back to 640x480, position counters, window and queue cleared;
// the line stores are not cleared and are valid once the first two rows of a
// frame have been written.
module sobel_edge_magnitude_3x3_top #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sem_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sem_pkg::out_item_t                  m_data,
    input  logic                                cfg_wr_en,
    input  logic [sem_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]           cfg_wdata
);

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int WCW        = CW + 1;
    localparam int EW         = (WCW > sem_pkg::CFG_W) ? WCW : sem_pkg::CFG_W;
    localparam int PW         = (CW > sem_pkg::COL_W) ? CW : sem_pkg::COL_W;
    localparam int RW         = sem_pkg::ROW_W + 1;
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int PIX_W      = sem_pkg::PIX_W;
    localparam int GRAD_W     = sem_pkg::GRAD_W;

    typedef struct packed {
        logic                        emit;
        logic [sem_pkg::ROW_W-1:0]   row;
        logic [sem_pkg::COL_W-1:0]   col;
        logic                        last;
    } pos_meta_t;

    function automatic logic [WCW-1:0] clamp_width(input logic [sem_pkg::CFG_W-1:0] v);
        logic [EW-1:0] e;
        e = EW'(v);
        if (e < EW'(sem_pkg::MIN_SIZE)) begin
            e = EW'(sem_pkg::MIN_SIZE);
        end else if (e > EW'(MAX_WIDTH)) begin
            e = EW'(MAX_WIDTH);
        end
        return WCW'(e);
    endfunction

    function automatic logic [sem_pkg::CFG_W-1:0] clamp_height(
        input logic [sem_pkg::CFG_W-1:0] v
    );
        return (v < sem_pkg::MIN_SIZE) ? sem_pkg::MIN_SIZE : v;
    endfunction

    // size registers hold the effective values
    logic [WCW-1:0]              width_reg;
    logic [sem_pkg::CFG_W-1:0]   height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= clamp_width(sem_pkg::IMAGE_WIDTH_RESET);
            height_reg <= clamp_height(sem_pkg::IMAGE_HEIGHT_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sem_pkg::REG_IMAGE_WIDTH: begin
                    width_reg <= clamp_width(cfg_wdata);
                end
                sem_pkg::REG_IMAGE_HEIGHT: begin
                    height_reg <= clamp_height(cfg_wdata);
                end
                default: begin
                end
            endcase
        end
    end

    // position of the incoming pixel
    logic [CW-1:0]             col_reg, col_next;
    logic [sem_pkg::ROW_W-1:0] row_reg, row_next;
    logic [WCW-1:0]            c0, c1, cn;
    logic [RW-1:0]             r0, r1, rn, h_ext;
    logic [PW-1:0]             col_dec;
    logic [RW-1:0]             row_dec;
    logic [CW-1:0]             pos_addr;
    pos_meta_t                 pos_meta;
    logic                      s_accept;

    always_comb begin
        h_ext = RW'(height_reg);
        c0 = s_data.frame_start ? '0 : WCW'(col_reg);
        r0 = s_data.frame_start ? '0 : RW'(row_reg);
        if (c0 >= width_reg) begin
            c1 = '0;
            r1 = r0 + RW'(1);
        end else begin
            c1 = c0;
            r1 = r0;
        end
        if (r1 >= h_ext) begin
            r1 = '0;
        end
        cn = c1 + WCW'(1);
        rn = r1;
        if (cn >= width_reg) begin
            cn = '0;
            rn = r1 + RW'(1);
            if (rn >= h_ext) begin
                rn = '0;
            end
        end
        col_next = CW'(cn);
        row_next = rn[sem_pkg::ROW_W-1:0];
        pos_addr = CW'(c1);
        col_dec  = PW'(c1) - PW'(1);
        row_dec  = r1 - RW'(1);
        pos_meta.emit = (r1 >= RW'(2)) && (c1 >= WCW'(2));
        pos_meta.row  = row_dec[sem_pkg::ROW_W-1:0];
        pos_meta.col  = col_dec[sem_pkg::COL_W-1:0];
        pos_meta.last = (r1 == h_ext - RW'(1)) && (c1 == width_reg - WCW'(1));
    end

    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage a: line store read in flight
    logic             a_valid_reg;
    logic [PIX_W-1:0] a_pix_reg;
    logic [CW-1:0]    a_addr_reg;
    logic             a_fwd_reg;
    pos_meta_t        a_meta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= s_accept;
        end
        if (s_accept) begin
            a_pix_reg  <= s_data.pixel_value;
            a_addr_reg <= pos_addr;
            a_fwd_reg  <= a_valid_reg && (a_addr_reg == pos_addr);
            a_meta_reg <= pos_meta;
        end
    end

    logic [PIX_W-1:0] up_rdata, mid_rdata, up_val, mid_val;
    logic [PIX_W-1:0] fwd_up_reg, fwd_mid_reg;

    // same entry written in the cycle it was read
    assign up_val  = a_fwd_reg ? fwd_up_reg  : up_rdata;
    assign mid_val = a_fwd_reg ? fwd_mid_reg : mid_rdata;

    always_ff @(posedge aclk) begin
        if (a_valid_reg) begin
            fwd_up_reg  <= mid_val;
            fwd_mid_reg <= a_pix_reg;
        end
    end

    sem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .aclk    (aclk),
        .wr_en   (a_valid_reg),
        .wr_addr (a_addr_reg),
        .wr_data (mid_val),
        .rd_en   (s_accept),
        .rd_addr (pos_addr),
        .rd_data (up_rdata)
    );

    sem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .aclk    (aclk),
        .wr_en   (a_valid_reg),
        .wr_addr (a_addr_reg),
        .wr_data (a_pix_reg),
        .rd_en   (s_accept),
        .rd_addr (pos_addr),
        .rd_data (mid_rdata)
    );

    // stage b: column chain shifts, newest column enters cell 2
    sem_pkg::win_col_t new_col;
    sem_pkg::win_col_t col1, col2;
    sem_pkg::col_tap_t tap0, tap1, tap2;

    assign new_col.top = up_val;
    assign new_col.mid = mid_val;
    assign new_col.bot = a_pix_reg;

    sem_col_cell u_cell2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (a_valid_reg),
        .col_in   (new_col),
        .col_out  (col2),
        .tap      (tap2)
    );

    sem_col_cell u_cell1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (a_valid_reg),
        .col_in   (col2),
        .col_out  (col1),
        .tap      (tap1)
    );

    sem_col_cell u_cell0 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (a_valid_reg),
        .col_in   (col1),
        .col_out  (),
        .tap      (tap0)
    );

    logic      b_valid_reg;
    pos_meta_t b_meta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= a_valid_reg;
        end
        if (a_valid_reg) begin
            b_meta_reg <= a_meta_reg;
        end
    end

    // stage c: gradients
    logic signed [GRAD_W-1:0] gx_next, gy_next, c_gx_reg, c_gy_reg;
    logic                     c_valid_reg;
    pos_meta_t                c_meta_reg;

    assign gx_next = $signed(GRAD_W'({1'b0, tap2.col_sum}))
                   - $signed(GRAD_W'({1'b0, tap0.col_sum}));
    assign gy_next = GRAD_W'(tap0.vert_diff) + (GRAD_W'(tap1.vert_diff) <<< 1)
                   + GRAD_W'(tap2.vert_diff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= b_valid_reg;
        end
        if (b_valid_reg) begin
            c_gx_reg   <= gx_next;
            c_gy_reg   <= gy_next;
            c_meta_reg <= b_meta_reg;
        end
    end

    function automatic logic [PIX_W-1:0] sat_abs(input logic signed [GRAD_W-1:0] g);
        logic [GRAD_W-1:0] a;
        a = g[GRAD_W-1] ? GRAD_W'(-g) : GRAD_W'(g);
        return (a > GRAD_W'(8'hFF)) ? 8'hFF : a[PIX_W-1:0];
    endfunction

    logic [PIX_W:0]      mag_sum;
    logic [PIX_W-1:0]    mag_half, edge_val;
    sem_pkg::out_item_t  result;
    logic                push, drop, pop;

    // halve with ties to even
    always_comb begin
        mag_sum  = (PIX_W + 1)'(sat_abs(c_gx_reg)) + (PIX_W + 1)'(sat_abs(c_gy_reg));
        mag_half = mag_sum[PIX_W:1];
        edge_val = (mag_sum[0] && mag_half[0]) ? mag_half + PIX_W'(1) : mag_half;
        result.edge_value = edge_val;
        result.out_row    = c_meta_reg.row;
        result.out_col    = c_meta_reg.col;
        result.frame_last = c_meta_reg.last;
    end

    assign push = c_valid_reg && c_meta_reg.emit;
    assign drop = c_valid_reg && !c_meta_reg.emit;
    assign pop  = m_valid && m_ready;

    // output queue
    sem_pkg::out_item_t fifo_mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     fill_reg, fill_next;
    logic [PTR_W:0]     credit_reg, credit_next;

    always_comb begin
        fill_next = fill_reg;
        if (push) begin
            fill_next = fill_next + (PTR_W + 1)'(1);
        end
        if (pop) begin
            fill_next = fill_next - (PTR_W + 1)'(1);
        end
        credit_next = credit_reg;
        if (s_accept) begin
            credit_next = credit_next + (PTR_W + 1)'(1);
        end
        if (pop) begin
            credit_next = credit_next - (PTR_W + 1)'(1);
        end
        if (drop) begin
            credit_next = credit_next - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            credit_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            fill_reg   <= fill_next;
            credit_reg <= credit_next;
        end
        if (push) begin
            fifo_mem_reg[wr_ptr_reg] <= result;
        end
    end

    assign s_ready = credit_reg < (PTR_W + 1)'(FIFO_DEPTH);
    assign m_valid = fill_reg != '0;
    assign m_data  = fifo_mem_reg[rd_ptr_reg];

endmodule

// ===== hdl/sem_checker.sv =====
module sem_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input sem_pkg::out_item_t m_data
);

    // reset empties the output side
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output request present after reset");

    // stalled request holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled output request changed");

    // only interior positions come out
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.out_row != '0) && (m_data.out_col != '0))
        else $error("border position on output");

endmodule

bind sobel_edge_magnitude_3x3_top sem_checker u_sem_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
